>>> rtl/tgo_pkg.sv
`default_nettype none

package tgo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam int ATAN_N       = 24;
  localparam int ATAN_IDX_W   = $clog2(ATAN_N);

  localparam int RATE_W  = 24;
  localparam int YAW_W   = 15;
  localparam int POS_W   = 48;
  localparam int UW_W    = 32;
  localparam int SCALE_W = 32;
  localparam int MOUNT_W = 2;
  localparam int CFG_W   = SCALE_W;
  localparam int CFG_IDX_W = 1;

  localparam int DIFF_W = YAW_W + 2;
  localparam int OFF_W  = UW_W + 1;

  localparam int MUL_A_W    = RATE_W + 1;
  localparam int MUL_B_W    = SCALE_W + 1;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int DISP_SHIFT = 8;
  localparam int HALF_W     = POS_W / 2;
  localparam int CS_W       = 32;
  localparam int Z_W        = 35;
  localparam int YAW_TO_Z   = 18;
  localparam int FRAC_SHIFT = 30;
  localparam int PROD_W     = MUL_P_W + HALF_W - 1;
  localparam int Q_W        = PROD_W - FRAC_SHIFT;
  localparam int ACC_W      = Q_W + 1;

  localparam logic signed [DIFF_W-1:0] YAW_PI      = DIFF_W'(12868);
  localparam logic signed [DIFF_W-1:0] YAW_PI_NEG  = -DIFF_W'(12868);
  localparam logic signed [OFF_W-1:0]  YAW_TURN    = OFF_W'(25736);
  localparam logic signed [UW_W-1:0]   UW_MAX      = {1'b0, {(UW_W-1){1'b1}}};
  localparam logic signed [UW_W-1:0]   UW_MIN      = {1'b1, {(UW_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0]  POS_MAX     = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]  POS_MIN     = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [Z_W-1:0]    PI_Q30      = Z_W'(64'sd3373259426);
  localparam logic signed [Z_W-1:0]    HALF_PI_Q30 = Z_W'(64'sd1686629713);
  localparam logic signed [Z_W-1:0]    HALF_PI_NEG = -Z_W'(64'sd1686629713);
  localparam logic signed [CS_W-1:0]   GAIN_Q30    = CS_W'(64'sd652032874);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOUNT = 1'b0,
    REG_SCALE = 1'b1
  } reg_idx_t;

  typedef enum logic [MOUNT_W-1:0] {
    MNT_NEG_B_A     = 2'd0,
    MNT_A_B         = 2'd1,
    MNT_B_NEG_A     = 2'd2,
    MNT_NEG_A_NEG_B = 2'd3
  } mount_t;

  localparam mount_t             MNT_RESET   = MNT_B_NEG_A;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(124554);

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_RA,
    MUL_RB,
    MUL_LO,
    MUL_HI
  } mul_op_t;

  typedef enum logic {SEL_LX, SEL_LY} msel_t;
  typedef enum logic {SEL_COS, SEL_SIN} csel_t;
  typedef enum logic {ACC_X, ACC_Y} acc_sel_t;

  localparam int PROG_LEN = 15;
  localparam int PC_W     = $clog2(PROG_LEN);

  typedef enum logic [PC_W-1:0] {
    ST_DISP_A,
    ST_DISP_B,
    ST_CORDIC_INIT,
    ST_CORDIC,
    ST_PX0_LO,
    ST_PX0_HI,
    ST_PX1_LO,
    ST_PX1_HI,
    ST_PY0_LO,
    ST_PY0_HI,
    ST_PY1_LO,
    ST_PY1_HI,
    ST_TAIL_COMB,
    ST_TAIL_ACC,
    ST_FINISH
  } step_t;

  typedef struct packed {
    mul_op_t  mul_op;
    msel_t    m_sel;
    csel_t    c_sel;
    logic     ld_da;
    logic     ld_db;
    logic     cordic_init;
    logic     cordic_step;
    logic     acc_ld;
    logic     comb;
    logic     acc_en;
    acc_sel_t acc_sel;
    logic     acc_sub;
    logic     finish;
    logic     jmp_nlast;
    step_t    jmp_tgt;
  } ctrl_t;

  typedef struct packed {
    logic cordic_last;
    logic out_stall;
  } stat_t;

  function automatic ctrl_t ucode(step_t pc);
    ctrl_t w;
    w = '0;
    case (pc)
      ST_DISP_A: begin
        w.mul_op = MUL_RA;
      end
      ST_DISP_B: begin
        w.mul_op = MUL_RB;
        w.ld_da  = 1'b1;
      end
      ST_CORDIC_INIT: begin
        w.ld_db       = 1'b1;
        w.cordic_init = 1'b1;
        w.acc_ld      = 1'b1;
      end
      ST_CORDIC: begin
        w.cordic_step = 1'b1;
        w.jmp_nlast   = 1'b1;
        w.jmp_tgt     = ST_CORDIC;
      end
      ST_PX0_LO: begin
        w.mul_op = MUL_LO;
        w.m_sel  = SEL_LX;
        w.c_sel  = SEL_COS;
      end
      ST_PX0_HI: begin
        w.mul_op = MUL_HI;
        w.m_sel  = SEL_LX;
        w.c_sel  = SEL_COS;
      end
      ST_PX1_LO: begin
        w.comb   = 1'b1;
        w.mul_op = MUL_LO;
        w.m_sel  = SEL_LY;
        w.c_sel  = SEL_SIN;
      end
      ST_PX1_HI: begin
        w.acc_en  = 1'b1;
        w.acc_sel = ACC_X;
        w.mul_op  = MUL_HI;
        w.m_sel   = SEL_LY;
        w.c_sel   = SEL_SIN;
      end
      ST_PY0_LO: begin
        w.comb   = 1'b1;
        w.mul_op = MUL_LO;
        w.m_sel  = SEL_LX;
        w.c_sel  = SEL_SIN;
      end
      ST_PY0_HI: begin
        w.acc_en  = 1'b1;
        w.acc_sel = ACC_X;
        w.acc_sub = 1'b1;
        w.mul_op  = MUL_HI;
        w.m_sel   = SEL_LX;
        w.c_sel   = SEL_SIN;
      end
      ST_PY1_LO: begin
        w.comb   = 1'b1;
        w.mul_op = MUL_LO;
        w.m_sel  = SEL_LY;
        w.c_sel  = SEL_COS;
      end
      ST_PY1_HI: begin
        w.acc_en  = 1'b1;
        w.acc_sel = ACC_Y;
        w.mul_op  = MUL_HI;
        w.m_sel   = SEL_LY;
        w.c_sel   = SEL_COS;
      end
      ST_TAIL_COMB: begin
        w.comb = 1'b1;
      end
      ST_TAIL_ACC: begin
        w.acc_en  = 1'b1;
        w.acc_sel = ACC_Y;
      end
      ST_FINISH: begin
        w.finish = 1'b1;
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic signed [Z_W-1:0] atan_q30(logic [ATAN_IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      default: v = '0;
    endcase
    return $signed({{(Z_W-32){1'b0}}, v});
  endfunction

endpackage

`default_nettype wire

>>> rtl/tgo_if.sv
`default_nettype none

interface tgo_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tgo_pkg::RATE_W-1:0]   wheel_a_rate;
  logic signed [tgo_pkg::RATE_W-1:0]   wheel_b_rate;
  logic signed [tgo_pkg::YAW_W-1:0]    yaw_angle;

  modport source (output valid, output wheel_a_rate, output wheel_b_rate,
                  output yaw_angle, input ready);
  modport sink   (input valid, input wheel_a_rate, input wheel_b_rate,
                  input yaw_angle, output ready);
endinterface

interface tgo_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tgo_pkg::POS_W-1:0]  position_x;
  logic signed [tgo_pkg::POS_W-1:0]  position_y;
  logic signed [tgo_pkg::UW_W-1:0]   yaw_unwrapped;

  modport source (output valid, output position_x, output position_y,
                  output yaw_unwrapped, input ready);
  modport sink   (input valid, input position_x, input position_y,
                  input yaw_unwrapped, output ready);
endinterface

`default_nettype wire

>>> rtl/tgo_seq.sv
`default_nettype none

module tgo_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  tgo_pkg::stat_t  stat,
  output tgo_pkg::ctrl_t  ctrl,
  output logic            busy
);

  tgo_pkg::step_t pc_r, pc_nxt;
  logic           busy_r, busy_nxt;
  tgo_pkg::ctrl_t rom;
  logic           stall;

  always_comb begin
    rom      = tgo_pkg::ucode(pc_r);
    stall    = rom.finish && stat.out_stall;
    ctrl     = '0;
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      pc_nxt   = tgo_pkg::ST_DISP_A;
      busy_nxt = 1'b1;
    end else if (busy_r && !stall) begin
      ctrl = rom;
      if (rom.finish) begin
        busy_nxt = 1'b0;
        pc_nxt   = tgo_pkg::ST_DISP_A;
      end else if (rom.jmp_nlast && !stat.cordic_last) begin
        pc_nxt = rom.jmp_tgt;
      end else begin
        pc_nxt = tgo_pkg::step_t'(pc_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= tgo_pkg::ST_DISP_A;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

>>> rtl/tgo_dp.sv
`default_nettype none

module tgo_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [tgo_pkg::RATE_W-1:0]   wheel_a_rate,
  input  logic signed [tgo_pkg::RATE_W-1:0]   wheel_b_rate,
  input  logic signed [tgo_pkg::YAW_W-1:0]    yaw_angle,
  input  logic                                cfg_wr_en,
  input  logic [tgo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tgo_pkg::CFG_W-1:0]           cfg_wdata,
  input  tgo_pkg::ctrl_t                      ctrl,
  input  logic                                out_ready,
  output tgo_pkg::stat_t                      stat,
  output logic                                out_valid,
  output logic signed [tgo_pkg::POS_W-1:0]    position_x,
  output logic signed [tgo_pkg::POS_W-1:0]    position_y,
  output logic signed [tgo_pkg::UW_W-1:0]     yaw_unwrapped
);

  // config
  tgo_pkg::mount_t                     mount_r;
  logic [tgo_pkg::SCALE_W-1:0]         scale_r;

  // heading history
  logic signed [tgo_pkg::YAW_W-1:0]    prev_yaw_r;
  logic signed [tgo_pkg::UW_W-1:0]     turn_off_r, turn_off_nxt;
  logic signed [tgo_pkg::UW_W-1:0]     yaw_uw_r, yaw_uw_nxt;
  logic signed [tgo_pkg::UW_W-1:0]     yaw_out_r;
  logic signed [tgo_pkg::DIFF_W-1:0]   diff;
  logic signed [tgo_pkg::OFF_W-1:0]    off_wide, uw_wide;

  // latched item
  logic signed [tgo_pkg::RATE_W-1:0]   ra_r, rb_r;
  logic signed [tgo_pkg::YAW_W-1:0]    yaw_r;

  // displacements
  logic signed [tgo_pkg::POS_W-1:0]    da_r, db_r, lx, ly, m_op;

  // CORDIC
  logic signed [tgo_pkg::CS_W-1:0]     x_r, y_r, dx, dy, sin_v, cos_v, c_op;
  logic signed [tgo_pkg::Z_W-1:0]      z_r, z0, z_init, atan_v;
  logic                                neg_r, neg_init;
  logic [tgo_pkg::ITER_W-1:0]          iter_r;

  // shared multiplier and product assembly
  logic signed [tgo_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [tgo_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [tgo_pkg::MUL_P_W-1:0]  mul_p, mul_r, lo_r;
  logic signed [tgo_pkg::PROD_W-1:0]   prod;
  logic signed [tgo_pkg::Q_W-1:0]      q_r;

  // position
  logic signed [tgo_pkg::ACC_W-1:0]    acc_x_r, acc_y_r;
  logic signed [tgo_pkg::POS_W-1:0]    world_x_r, world_y_r, world_x_nxt, world_y_nxt;
  logic                                out_valid_r;

  // heading unwrap
  always_comb begin
    diff     = tgo_pkg::DIFF_W'(yaw_angle) - tgo_pkg::DIFF_W'(prev_yaw_r);
    off_wide = tgo_pkg::OFF_W'(turn_off_r);
    if (diff < tgo_pkg::YAW_PI_NEG) begin
      off_wide = off_wide + tgo_pkg::YAW_TURN;
    end else if (diff > tgo_pkg::YAW_PI) begin
      off_wide = off_wide - tgo_pkg::YAW_TURN;
    end
    if (off_wide[tgo_pkg::OFF_W-1] != off_wide[tgo_pkg::OFF_W-2]) begin
      turn_off_nxt = off_wide[tgo_pkg::OFF_W-1] ? tgo_pkg::UW_MIN : tgo_pkg::UW_MAX;
    end else begin
      turn_off_nxt = off_wide[tgo_pkg::UW_W-1:0];
    end
    uw_wide = tgo_pkg::OFF_W'(yaw_angle) + tgo_pkg::OFF_W'(turn_off_nxt);
    if (uw_wide[tgo_pkg::OFF_W-1] != uw_wide[tgo_pkg::OFF_W-2]) begin
      yaw_uw_nxt = uw_wide[tgo_pkg::OFF_W-1] ? tgo_pkg::UW_MIN : tgo_pkg::UW_MAX;
    end else begin
      yaw_uw_nxt = uw_wide[tgo_pkg::UW_W-1:0];
    end
  end

  // mount mapping
  always_comb begin
    case (mount_r)
      tgo_pkg::MNT_NEG_B_A: begin
        lx = -db_r;
        ly = da_r;
      end
      tgo_pkg::MNT_A_B: begin
        lx = da_r;
        ly = db_r;
      end
      tgo_pkg::MNT_B_NEG_A: begin
        lx = db_r;
        ly = -da_r;
      end
      default: begin
        lx = -da_r;
        ly = -db_r;
      end
    endcase
  end

  // CORDIC step and fold
  always_comb begin
    z0 = tgo_pkg::Z_W'(yaw_r) <<< tgo_pkg::YAW_TO_Z;
    if (z0 > tgo_pkg::HALF_PI_Q30) begin
      z_init   = z0 - tgo_pkg::PI_Q30;
      neg_init = 1'b1;
    end else if (z0 < tgo_pkg::HALF_PI_NEG) begin
      z_init   = z0 + tgo_pkg::PI_Q30;
      neg_init = 1'b1;
    end else begin
      z_init   = z0;
      neg_init = 1'b0;
    end
    dx     = y_r >>> iter_r;
    dy     = x_r >>> iter_r;
    atan_v = tgo_pkg::atan_q30(tgo_pkg::ATAN_IDX_W'(iter_r));
    sin_v  = neg_r ? -y_r : y_r;
    cos_v  = neg_r ? -x_r : x_r;
  end

  // multiplier operands
  always_comb begin
    m_op = (ctrl.m_sel == tgo_pkg::SEL_LY) ? ly : lx;
    c_op = (ctrl.c_sel == tgo_pkg::SEL_SIN) ? sin_v : cos_v;
    case (ctrl.mul_op)
      tgo_pkg::MUL_RA: begin
        mul_a = tgo_pkg::MUL_A_W'(ra_r);
        mul_b = $signed({1'b0, scale_r});
      end
      tgo_pkg::MUL_RB: begin
        mul_a = tgo_pkg::MUL_A_W'(rb_r);
        mul_b = $signed({1'b0, scale_r});
      end
      tgo_pkg::MUL_LO: begin
        mul_a = $signed({1'b0, m_op[tgo_pkg::HALF_W-1:0]});
        mul_b = tgo_pkg::MUL_B_W'(c_op);
      end
      tgo_pkg::MUL_HI: begin
        mul_a = tgo_pkg::MUL_A_W'($signed(m_op[tgo_pkg::POS_W-1:tgo_pkg::HALF_W]));
        mul_b = tgo_pkg::MUL_B_W'(c_op);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
    prod  = (tgo_pkg::PROD_W'(mul_r) <<< tgo_pkg::HALF_W) + tgo_pkg::PROD_W'(lo_r);
  end

  // saturate positions
  always_comb begin
    if (acc_x_r > tgo_pkg::ACC_W'(tgo_pkg::POS_MAX)) begin
      world_x_nxt = tgo_pkg::POS_MAX;
    end else if (acc_x_r < tgo_pkg::ACC_W'(tgo_pkg::POS_MIN)) begin
      world_x_nxt = tgo_pkg::POS_MIN;
    end else begin
      world_x_nxt = acc_x_r[tgo_pkg::POS_W-1:0];
    end
    if (acc_y_r > tgo_pkg::ACC_W'(tgo_pkg::POS_MAX)) begin
      world_y_nxt = tgo_pkg::POS_MAX;
    end else if (acc_y_r < tgo_pkg::ACC_W'(tgo_pkg::POS_MIN)) begin
      world_y_nxt = tgo_pkg::POS_MIN;
    end else begin
      world_y_nxt = acc_y_r[tgo_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mount_r     <= tgo_pkg::MNT_RESET;
      scale_r     <= tgo_pkg::SCALE_RESET;
      prev_yaw_r  <= '0;
      turn_off_r  <= '0;
      world_x_r   <= '0;
      world_y_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          tgo_pkg::REG_MOUNT: mount_r <= tgo_pkg::mount_t'(cfg_wdata[tgo_pkg::MOUNT_W-1:0]);
          tgo_pkg::REG_SCALE: scale_r <= cfg_wdata[tgo_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end
      if (start) begin
        prev_yaw_r <= yaw_angle;
        turn_off_r <= turn_off_nxt;
      end
      if (ctrl.finish) begin
        world_x_r   <= world_x_nxt;
        world_y_r   <= world_y_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ra_r     <= wheel_a_rate;
      rb_r     <= wheel_b_rate;
      yaw_r    <= yaw_angle;
      yaw_uw_r <= yaw_uw_nxt;
    end
    if (ctrl.mul_op != tgo_pkg::MUL_NONE) begin
      mul_r <= mul_p;
    end
    if (ctrl.mul_op == tgo_pkg::MUL_HI) begin
      lo_r <= mul_r;
    end
    if (ctrl.ld_da) begin
      da_r <= mul_r[tgo_pkg::DISP_SHIFT +: tgo_pkg::POS_W];
    end
    if (ctrl.ld_db) begin
      db_r <= mul_r[tgo_pkg::DISP_SHIFT +: tgo_pkg::POS_W];
    end
    if (ctrl.cordic_init) begin
      x_r    <= tgo_pkg::GAIN_Q30;
      y_r    <= '0;
      z_r    <= z_init;
      neg_r  <= neg_init;
      iter_r <= '0;
    end else if (ctrl.cordic_step) begin
      if (!z_r[tgo_pkg::Z_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atan_v;
      end
      iter_r <= iter_r + 1'b1;
    end
    if (ctrl.comb) begin
      q_r <= prod[tgo_pkg::FRAC_SHIFT +: tgo_pkg::Q_W];
    end
    if (ctrl.acc_ld) begin
      acc_x_r <= tgo_pkg::ACC_W'(world_x_r);
      acc_y_r <= tgo_pkg::ACC_W'(world_y_r);
    end else if (ctrl.acc_en) begin
      if (ctrl.acc_sel == tgo_pkg::ACC_Y) begin
        acc_y_r <= ctrl.acc_sub ? acc_y_r - tgo_pkg::ACC_W'(q_r)
                                : acc_y_r + tgo_pkg::ACC_W'(q_r);
      end else begin
        acc_x_r <= ctrl.acc_sub ? acc_x_r - tgo_pkg::ACC_W'(q_r)
                                : acc_x_r + tgo_pkg::ACC_W'(q_r);
      end
    end
    if (ctrl.finish) begin
      yaw_out_r <= yaw_uw_r;
    end
  end

  assign stat.cordic_last = (iter_r == tgo_pkg::ITER_W'(tgo_pkg::CORDIC_STEPS - 1));
  assign stat.out_stall   = out_valid_r && !out_ready;
  assign out_valid        = out_valid_r;
  assign position_x       = world_x_r;
  assign position_y       = world_y_r;
  assign yaw_unwrapped    = yaw_out_r;

endmodule

`default_nettype wire

>>> rtl/two_wheel_gyro_odometry.sv
// Steps per input beat: wheel displacements, CORDIC, rotation products, accumulate, finish.
// The next beat is taken only after finish; all steps share one 25x33 multiplier
// (two partial products per rotation term) and the one CORDIC stage.
// A waiting result holds only the final step; the next beat is taken once it is written.
// Reset (sync, rst_n low): position, turn offset and last heading cleared, mount = 2,
// scale = 124554, no result pending.
`default_nettype none

module two_wheel_gyro_odometry (
  input  logic                           clk,
  input  logic                           rst_n,
  tgo_in_if.sink                         in_chan,
  tgo_out_if.source                      out_chan,
  input  logic                           cfg_wr_en,
  input  logic [tgo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tgo_pkg::CFG_W-1:0]      cfg_wdata
);

  tgo_pkg::ctrl_t ctrl;
  tgo_pkg::stat_t stat;
  logic           busy;
  logic           start;

  assign in_chan.ready = !busy;
  assign start         = in_chan.valid && !busy;

  tgo_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  tgo_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .wheel_a_rate  (in_chan.wheel_a_rate),
    .wheel_b_rate  (in_chan.wheel_b_rate),
    .yaw_angle     (in_chan.yaw_angle),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .ctrl          (ctrl),
    .out_ready     (out_chan.ready),
    .stat          (stat),
    .out_valid     (out_chan.valid),
    .position_x    (out_chan.position_x),
    .position_y    (out_chan.position_y),
    .yaw_unwrapped (out_chan.yaw_unwrapped)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_chan.ready)
    else $error("input taken while a beat is in flight");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.finish |-> !(out_chan.valid && !out_chan.ready))
    else $error("result written over an untaken beat");

  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $rose(in_chan.ready))
    else $error("result valid without sequence end");

endmodule

`default_nettype wire
